/* rtl/bfs_pkg.sv */
`timescale 1ns / 1ps

package bfs_pkg;

   // Width of one adjacency row word; also the node limit the field widths allow
   localparam int ROW_BITS      = 32;
   // Default storage depth (nodes)
   localparam int MAX_NODES_DEF = 32;
   // node_count after reset
   localparam logic [5:0] NODE_COUNT_RESET = 6'd32;

   // Input word: one adjacency row
   typedef struct packed {
      logic [4:0]          row_index;
      logic [ROW_BITS-1:0] row_bits;
      logic                last_row;
   } req_type;

   // Result word: distance of one node
   typedef struct packed {
      logic [4:0] node_index;
      logic [4:0] hop_distance;
      logic       reachable;
      logic       last;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic row_wr;   // store the incoming row
      logic init;     // seed the search with node 0
      logic u_rd;     // pop queue head, read its row and distance
      logic u_latch;  // capture row and distance of the popped node
      logic v_eval;   // test neighbor candidate v
      logic k_clr;    // restart result counter
      logic k_load;   // load result register for node k
      logic k_inc;    // advance to next node
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic queue_more; // queue holds a node to expand
      logic v_last;     // candidate is the last node in use
      logic k_last;     // result node is the last node in use
      logic rsp_taken;  // result word taken this cycle
   } status_type;

endpackage

/* rtl/bfs_ctrl.sv */
`timescale 1ns / 1ps

module bfs_ctrl import bfs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last_row,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [3:0] S_LOAD   = 4'd0;
   localparam logic [3:0] S_INIT   = 4'd1;
   localparam logic [3:0] S_DEQ    = 4'd2;
   localparam logic [3:0] S_UADDR  = 4'd3;
   localparam logic [3:0] S_ULATCH = 4'd4;
   localparam logic [3:0] S_VADDR  = 4'd5;
   localparam logic [3:0] S_VEVAL  = 4'd6;
   localparam logic [3:0] S_KADDR  = 4'd7;
   localparam logic [3:0] S_KLOAD  = 4'd8;
   localparam logic [3:0] S_KWAIT  = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   // Rows are taken only while loading
   assign req_stall = (state_ff != S_LOAD);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_LOAD: begin
            cmd.row_wr = req_valid;
            if (req_valid && req_last_row) state_in = S_INIT;
         end
         S_INIT: begin
            cmd.init = 1'b1;
            state_in = S_DEQ;
         end
         S_DEQ: begin
            if (status.queue_more) begin
               state_in = S_UADDR;
            end else begin
               cmd.k_clr = 1'b1;
               state_in  = S_KADDR;
            end
         end
         S_UADDR: begin
            cmd.u_rd = 1'b1;
            state_in = S_ULATCH;
         end
         S_ULATCH: begin
            cmd.u_latch = 1'b1;
            state_in    = S_VADDR;
         end
         S_VADDR: begin
            state_in = S_VEVAL;
         end
         S_VEVAL: begin
            cmd.v_eval = 1'b1;
            state_in   = status.v_last ? S_DEQ : S_VADDR;
         end
         S_KADDR: begin
            state_in = S_KLOAD;
         end
         S_KLOAD: begin
            cmd.k_load = 1'b1;
            state_in   = S_KWAIT;
         end
         S_KWAIT: begin
            if (status.rsp_taken) begin
               if (status.k_last) begin
                  state_in = S_LOAD;
               end else begin
                  cmd.k_inc = 1'b1;
                  state_in  = S_KADDR;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/bfs_datapath.sv */
`timescale 1ns / 1ps

module bfs_datapath import bfs_pkg::*; #(
   parameter int MAX_NODES = MAX_NODES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_word,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output rsp_type    rsp_word,
   input  logic       csr_wr_en,
   input  logic [5:0] csr_wr_data,
   input  cmd_type    cmd,
   output status_type status
);

   // Nodes actually usable: storage depth, capped by the row word width
   localparam int NLIM = (MAX_NODES < ROW_BITS) ? MAX_NODES : ROW_BITS;
   localparam int IW   = $clog2(NLIM);
   localparam int CW   = $clog2(NLIM + 1);

   logic [NLIM-1:0] adj_mem   [NLIM];
   logic [4:0]      dist_mem  [NLIM];
   logic [IW-1:0]   queue_mem [NLIM];

   logic [5:0]      node_count_ff;
   logic [NLIM-1:0] visited_ff;
   logic [CW-1:0]   head_ff;
   logic [CW-1:0]   tail_ff;
   logic [CW-1:0]   v_ff;
   logic [CW-1:0]   k_ff;
   logic [IW-1:0]   u_ff;
   logic [NLIM-1:0] rowu_ff;
   logic [4:0]      du_ff;
   logic [NLIM-1:0] adj_rd_ff;
   logic [4:0]      dist_rd_ff;
   logic [IW-1:0]   q_rd_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_word_ff;

   logic [CW-1:0]   n_use;
   logic            row_in_range;
   logic [IW-1:0]   row_addr;
   logic [IW-1:0]   v_idx;
   logic [IW-1:0]   k_idx;
   logic [IW-1:0]   adj_raddr;
   logic [IW-1:0]   dist_raddr;
   logic            hit;
   logic            q_room;
   logic            rsp_taken;

   // Nodes in use: zero counts as one, saturate at the limit
   always_comb begin
      if (node_count_ff == 6'd0) begin
         n_use = CW'(1);
      end else if (node_count_ff > 6'(NLIM)) begin
         n_use = CW'(NLIM);
      end else begin
         n_use = CW'(node_count_ff);
      end
   end

   assign row_in_range = ({1'b0, req_word.row_index} < 6'(NLIM));
   assign row_addr     = IW'(req_word.row_index);
   assign v_idx        = v_ff[IW-1:0];
   assign k_idx        = k_ff[IW-1:0];
   assign adj_raddr    = cmd.u_rd ? q_rd_ff : v_idx;
   assign dist_raddr   = cmd.u_rd ? q_rd_ff : k_idx;
   assign q_room       = (tail_ff < n_use);
   assign rsp_taken    = rsp_valid_ff && !rsp_stall;

   // Undirected edge test: row u bit v, or row v bit u
   assign hit = cmd.v_eval && !visited_ff[v_idx] && (rowu_ff[v_idx] || adj_rd_ff[u_ff]);

   // Adjacency rows: written while loading, read for node u and each candidate v
   always_ff @(posedge clock) begin
      if (cmd.row_wr && row_in_range) adj_mem[row_addr] <= req_word.row_bits[NLIM-1:0];
      adj_rd_ff <= adj_mem[adj_raddr];
   end

   // Distance store
   always_ff @(posedge clock) begin
      if (cmd.init) begin
         dist_mem[0] <= 5'd0;
      end else if (hit) begin
         dist_mem[v_idx] <= du_ff + 5'd1;
      end
      dist_rd_ff <= dist_mem[dist_raddr];
   end

   // Frontier FIFO
   always_ff @(posedge clock) begin
      if (cmd.init) begin
         queue_mem[0] <= '0;
      end else if (hit && q_room) begin
         queue_mem[tail_ff[IW-1:0]] <= v_idx;
      end
      q_rd_ff <= queue_mem[head_ff[IW-1:0]];
   end

   // Control state: config, visited map, queue pointers, result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
         visited_ff    <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) node_count_ff <= csr_wr_data;
         if (cmd.init) begin
            visited_ff <= NLIM'(1);
            head_ff    <= '0;
            tail_ff    <= CW'(1);
         end
         if (cmd.u_rd) head_ff <= head_ff + CW'(1);
         if (hit) begin
            visited_ff[v_idx] <= 1'b1;
            if (q_room) tail_ff <= tail_ff + CW'(1);
         end
         if (cmd.k_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_taken) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers and result word
   always_ff @(posedge clock) begin
      if (cmd.u_rd) u_ff <= q_rd_ff;
      if (cmd.u_latch) begin
         rowu_ff <= adj_rd_ff;
         du_ff   <= dist_rd_ff;
         v_ff    <= '0;
      end
      if (cmd.v_eval) v_ff <= v_ff + CW'(1);
      if (cmd.k_clr) k_ff <= '0;
      if (cmd.k_inc) k_ff <= k_ff + CW'(1);
      if (cmd.k_load) begin
         rsp_word_ff.node_index   <= 5'(k_ff);
         rsp_word_ff.reachable    <= visited_ff[k_idx];
         rsp_word_ff.hop_distance <= visited_ff[k_idx] ? dist_rd_ff : 5'd0;
         rsp_word_ff.last         <= (k_ff == n_use - CW'(1));
      end
   end

   assign status.queue_more = (head_ff < tail_ff) && (head_ff < n_use);
   assign status.v_last     = (v_ff == n_use - CW'(1));
   assign status.k_last     = (k_ff == n_use - CW'(1));
   assign status.rsp_taken  = rsp_taken;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

/* rtl/bfs_hop_distance.sv */
`timescale 1ns / 1ps
// Breadth-first hop distances from node 0 over an undirected view of a graph.
// req channel: one adjacency row word per item (row_index, row_bits, last_row).
//   Rows are taken one per cycle while the block is loading; rows with an
//   index beyond storage are dropped. The word with last_row set starts the
//   search, and req_stall stays high until every result has been delivered.
// rsp channel: one word per node in use, ascending node order, last set on
//   the final node; unreachable nodes come out with reachable 0, distance 0.
// csr port: csr_wr_en/csr_wr_data writes node_count (0 acts as 1, values above
//   the storage depth saturate). Write only while the block is idle.
// Search after the last row: seed node 0, check the queue, fetch each dequeued
//   node's row and distance, then scan every candidate neighbor in turn (single
//   read port of the adjacency memory); when the queue is empty, emit one
//   result word per node in use, each waiting while the receiver stalls.
// rsp_valid is registered; while rsp_stall is high the word holds and the
//   search controller waits. Reset (synchronous) returns to loading, clears
//   the visited map and queue pointers and sets node_count to 32; stored
//   rows are not cleared and must be written before they are searched.

module bfs_hop_distance import bfs_pkg::*; #(
   parameter int MAX_NODES = MAX_NODES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_word,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_word,
   input  logic       csr_wr_en,
   input  logic [5:0] csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   // Sequencer
   bfs_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_last_row (req_word.last_row),
      .req_stall    (req_stall),
      .status       (status),
      .cmd          (cmd)
   );

   // Memories, visited map, queue pointers and result register
   bfs_datapath #(
      .MAX_NODES (MAX_NODES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_word    (req_word),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

// Tracks node count and stored rows, predicts the distance words of each search
// and checks the words that come back, oldest first.
class hop_scoreboard;
   logic [31:0] row_store [32];
   logic [5:0]  node_count;
   bfs_pkg::rsp_type expected_hops [$];
   int mismatches;
   int words_checked;
   int searches;
   int deepest_hop;
   int unreachable_seen;
   int fewest_nodes;
   int most_nodes;

   function new();
      foreach (row_store[i]) row_store[i] = '0;
      node_count       = bfs_pkg::NODE_COUNT_RESET;
      mismatches       = 0;
      words_checked    = 0;
      searches         = 0;
      deepest_hop      = 0;
      unreachable_seen = 0;
      fewest_nodes     = 32;
      most_nodes       = 1;
   endfunction

   // 0 acts as one node, anything above the storage depth saturates
   function int nodes_in_use();
      if (node_count == 6'd0) return 1;
      if (node_count > 6'd32) return 32;
      return int'(node_count);
   endfunction

   function void set_node_count(logic [5:0] value);
      node_count = value;
   endfunction

   function int pending();
      return expected_hops.size();
   endfunction

   task report(string what);
      mismatches++;
      $display("MISMATCH: %s", what);
   endtask

   // BFS from node 0 over the undirected view (row u bit v, or row v bit u)
   function void search_hops();
      int unsigned n;
      int unsigned head;
      int unsigned tail;
      int unsigned u;
      int unsigned v;
      logic [31:0] seen;
      logic [4:0]  hops [32];
      logic [4:0]  frontier [32];
      bfs_pkg::rsp_type word;
      n = nodes_in_use();
      foreach (hops[i]) hops[i] = '0;
      seen        = 32'h1;
      frontier[0] = '0;
      head        = 0;
      tail        = 1;
      while (head < tail && head < n) begin
         u = 32'(frontier[head]);
         head++;
         for (v = 0; v < n; v++) begin
            if (!seen[v] && (row_store[u][v] || row_store[v][u])) begin
               seen[v] = 1'b1;
               hops[v] = hops[u] + 5'd1;
               if (tail < n) begin
                  frontier[tail] = 5'(v);
                  tail++;
               end
            end
         end
      end
      // one word per node in use, ascending
      for (int k = 0; k < n; k++) begin
         word.node_index   = 5'(k);
         word.reachable    = seen[k];
         word.hop_distance = seen[k] ? hops[k] : 5'd0;
         word.last         = (k + 1 == n);
         expected_hops.push_back(word);
         if (seen[k] && int'(hops[k]) > deepest_hop) deepest_hop = int'(hops[k]);
         if (!seen[k]) unreachable_seen++;
      end
      searches++;
      if (n < fewest_nodes) fewest_nodes = n;
      if (n > most_nodes) most_nodes = n;
   endfunction

   function void note_row(bfs_pkg::req_type w);
      row_store[w.row_index] = w.row_bits;
      if (w.last_row) search_hops();
   endfunction

   task check_word(bfs_pkg::rsp_type got);
      bfs_pkg::rsp_type want;
      words_checked++;
      if (expected_hops.size() == 0) begin
         report($sformatf("word for node %0d with nothing expected", got.node_index));
         return;
      end
      want = expected_hops.pop_front();
      if (got.node_index !== want.node_index)
         report($sformatf("node_index %0d, expected %0d", got.node_index, want.node_index));
      if (got.hop_distance !== want.hop_distance)
         report($sformatf("node %0d hop_distance %0d, expected %0d", want.node_index,
                          got.hop_distance, want.hop_distance));
      if (got.reachable !== want.reachable)
         report($sformatf("node %0d reachable %b, expected %b", want.node_index,
                          got.reachable, want.reachable));
      if (got.last !== want.last)
         report($sformatf("node %0d last %b, expected %b", want.node_index,
                          got.last, want.last));
   endtask
endclass

module testbench;
   import bfs_pkg::*;

   localparam int TARGET_ROWS     = 170;
   localparam int HOLDOFF_CYCLES  = 400;
   localparam int SETTLE_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT  = 20000;

   // how the rows of one sequence are filled
   typedef enum int {
      SHAPE_CHAIN,
      SHAPE_SPARSE,
      SHAPE_THIN,
      SHAPE_DENSE,
      SHAPE_EXTREME
   } shape_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   req_type    req_word    = '0;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   rsp_type    rsp_word;
   logic       csr_wr_en   = 1'b0;
   logic [5:0] csr_wr_data = '0;

   hop_scoreboard board;
   bit          calm         = 1'b0;
   bit          holdoff_req  = 1'b0;
   bit          holdoff_done = 1'b0;
   int          holdoff_left = 0;
   int          idle_cycles  = 0;
   int          rows_sent    = 0;
   logic [31:0] rows_written = '0;

   always #2 clock = ~clock;

   bfs_hop_distance u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // receiver: check taken words, then pick next cycle's stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) board.check_word(rsp_word);
         if (holdoff_left > 0) begin
            holdoff_left = holdoff_left - 1;
            rsp_stall <= 1'b1;
         end else if (holdoff_req && !holdoff_done) begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < 32);
         end
      end
   end

   // watchdog: cycles in a row with no word taken on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", idle_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // offer one row word, with random gaps, until it is taken
   task automatic send_row(input int idx, input logic [31:0] bits, input logic fin);
      req_type w;
      w.row_index = 5'(idx);
      w.row_bits  = bits;
      w.last_row  = fin;
      while (!calm && $urandom_range(0, 99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      board.note_row(w);
      rows_written[idx] = 1'b1;
      rows_sent++;
   endtask

   task automatic go_quiet();
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // only while idle: drop valid, drain, then write
   task automatic write_node_count(input logic [5:0] value);
      go_quiet();
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      board.set_node_count(value);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [5:0] pick_node_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 6'($urandom_range(1, 8));
      if (r < 75) return 6'($urandom_range(9, 31));
      if (r < 85) return 6'($urandom_range(32, 63));
      case ($urandom_range(0, 3))
         0: return 6'd0;
         1: return 6'd1;
         2: return 6'd32;
         default: return 6'd63;
      endcase
   endfunction

   function automatic logic [31:0] make_row(input int idx, input int n,
                                            input shape_type shape, input bit backward);
      logic [31:0] in_use;
      logic [31:0] bits;
      in_use = (n >= 32) ? '1 : ((32'h1 << n) - 1);
      bits   = '0;
      case (shape)
         SHAPE_CHAIN: begin
            // path 0-1-2-..., stored one way or the other; noise only above the nodes in use
            if (!backward && idx + 1 < n) bits[idx + 1] = 1'b1;
            if (backward && idx > 0) bits[idx - 1] = 1'b1;
            bits |= $urandom & ~in_use;
         end
         SHAPE_SPARSE: begin
            bits[$urandom_range(0, 31)] = 1'b1;
            if ($urandom_range(0, 1)) bits[$urandom_range(0, n - 1)] = 1'b1;
         end
         SHAPE_THIN:  bits = $urandom & $urandom & $urandom;
         SHAPE_DENSE: bits = $urandom;
         default:     bits = $urandom_range(0, 1) ? '1 : '0;
      endcase
      return bits;
   endfunction

   initial begin
      int        seq;
      int        n;
      int        extras;
      int        idx;
      bit        backward;
      shape_type shape;
      int        row_order [$];

      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: one node with self loops and bits beyond the nodes in use
      write_node_count(6'd1);
      send_row(0, 32'hFFFF_FFFF, 1'b1);
      // node count zero acts as one
      write_node_count(6'd0);
      send_row(0, 32'h0, 1'b1);
      // two nodes, node 1 unreachable
      write_node_count(6'd2);
      send_row(1, 32'h0, 1'b0);
      send_row(0, 32'h0, 1'b1);
      // edge known only from row 1; last row carries the top index
      send_row(1, 32'h1, 1'b0);
      send_row(31, 32'hFFFF_FFFF, 1'b1);
      // three nodes in a line through the transpose
      write_node_count(6'd3);
      send_row(2, 32'h2, 1'b0);
      send_row(0, 32'h0, 1'b1);
      // all ones everywhere: every other node one hop away
      send_row(1, 32'hFFFF_FFFF, 1'b0);
      send_row(2, 32'hFFFF_FFFF, 1'b0);
      send_row(0, 32'hFFFF_FFFF, 1'b1);

      // random sequences of rows, each closed by a last row
      seq = 0;
      while (rows_sent < TARGET_ROWS) begin
         if (seq % 3 == 0) begin
            if (seq == 0) write_node_count(6'd63);
            else if (seq == 12) write_node_count(6'd32);
            else write_node_count(pick_node_count());
         end
         n    = board.nodes_in_use();
         calm = (seq >= 8 && seq < 12);
         case ($urandom_range(0, 9))
            0, 1:    shape = SHAPE_CHAIN;
            2, 3:    shape = SHAPE_SPARSE;
            4, 5, 6: shape = SHAPE_THIN;
            7, 8:    shape = SHAPE_DENSE;
            default: shape = SHAPE_EXTREME;
         endcase
         if (seq == 0) shape = SHAPE_CHAIN;
         backward = $urandom_range(0, 1);
         row_order.delete();
         if (shape == SHAPE_CHAIN) begin
            for (int i = 0; i < n; i++) row_order.push_back(i);
         end else begin
            // rows in use never written yet go first
            for (int i = 0; i < n; i++)
               if (!rows_written[i]) row_order.push_back(i);
            extras = $urandom_range(1, 6);
            repeat (extras) begin
               idx = ($urandom_range(0, 99) < 80) ? $urandom_range(0, n - 1)
                                                  : $urandom_range(0, 31);
               row_order.push_back(idx);
            end
         end
         foreach (row_order[i])
            send_row(row_order[i], make_row(row_order[i], n, shape, backward),
                     i == row_order.size() - 1);
         // long receiver hold-off while the next sequence is offered
         if (seq == 4) holdoff_req = 1'b1;
         seq++;
      end

      go_quiet();
      wait_drained();
      repeat (20) @(posedge clock);

      $display("%0d searches over %0d to %0d nodes from %0d row words; %0d distance words checked",
               board.searches, board.fewest_nodes, board.most_nodes, rows_sent,
               board.words_checked);
      $display("deepest hop %0d, %0d unreachable nodes, %0d mismatches",
               board.deepest_hop, board.unreachable_seen, board.mismatches);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
